>>> sv/efr_pkg.sv
package efr_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    EV_OPEN  = 2'd0,
    EV_STORE = 2'd1,
    EV_CLOSE = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    REG_START_CHAR = 2'd0,
    REG_END_CHAR   = 2'd1,
    REG_QUOTE_CHAR = 2'd2,
    REG_MAX_LENGTH = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       store_full;
  } rx_item_t;

  typedef struct packed {
    ev_kind_t   event_kind;
    logic [7:0] payload_byte;
    logic       last;
  } ev_item_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
  } event_t;

  // Events caused by one received byte: first, and optionally second.
  typedef struct packed {
    logic   two;
    event_t ev0;
    event_t ev1;
  } entry_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } q_status_t;

endpackage

>>> sv/efr_front.sv
module efr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  efr_pkg::rx_item_t rx_beat,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  efr_pkg::q_status_t q_stat,
  output logic              push,
  output efr_pkg::entry_t   push_entry
);
  import efr_pkg::*;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_START = 2'd1,
    MODE_RECV  = 2'd2,
    MODE_QUOTE = 2'd3
  } mode_t;

  logic [7:0] start_char;
  logic [7:0] end_char;
  logic [7:0] quote_char;
  logic [7:0] max_length;

  mode_t      mode, mode_next;
  logic [8:0] count, count_next;

  logic       take;
  logic [7:0] b;
  logic [8:0] cnt_base;
  logic [8:0] cnt_inc;
  logic       too_long;
  logic       is_start, is_end, is_quote;
  logic       rx_has;
  event_t     rx_ev;
  mode_t      rx_mode;
  logic [8:0] rx_cnt;
  event_t     store_ev;

  assign rx_stall = q_stat.full;
  assign take     = rx_valid && !rx_stall;
  assign b        = rx_beat.rx_byte;

  assign cnt_base = (mode == MODE_START) ? 9'd0 : count;
  assign cnt_inc  = (cnt_base == 9'h1FF) ? cnt_base : cnt_base + 9'd1;
  assign too_long = cnt_inc > {1'b0, max_length};
  assign is_start = b == start_char;
  assign is_end   = b == end_char;
  assign is_quote = b == quote_char;
  assign store_ev = '{kind: EV_STORE, data: b};

  // Handling of a byte inside a frame; start beats end, end beats quote.
  always_comb begin
    rx_has  = 1'b0;
    rx_ev   = '{kind: EV_CLOSE, data: 8'd0};
    rx_mode = MODE_RECV;
    rx_cnt  = cnt_base;
    if (is_start) begin
      rx_mode = MODE_START;
    end else if (is_end) begin
      rx_has  = 1'b1;
      rx_mode = MODE_WAIT;
    end else if (is_quote) begin
      rx_mode = MODE_QUOTE;
    end else begin
      rx_has  = 1'b1;
      rx_ev   = store_ev;
      rx_cnt  = cnt_inc;
      rx_mode = too_long ? MODE_WAIT : MODE_RECV;
    end
  end

  always_comb begin
    mode_next  = mode;
    count_next = count;
    push       = 1'b0;
    push_entry = '0;
    case (mode)
      MODE_WAIT: begin
        if (is_start) mode_next = MODE_START;
      end
      MODE_START: begin
        count_next = 9'd0;
        if (rx_beat.store_full) begin
          mode_next = MODE_WAIT;
        end else begin
          push           = 1'b1;
          push_entry.ev0 = '{kind: EV_OPEN, data: 8'd0};
          push_entry.two = rx_has;
          push_entry.ev1 = rx_ev;
          mode_next      = rx_mode;
          count_next     = rx_cnt;
        end
      end
      MODE_RECV: begin
        push           = rx_has;
        push_entry.ev0 = rx_ev;
        mode_next      = rx_mode;
        count_next     = rx_cnt;
      end
      MODE_QUOTE: begin
        push           = 1'b1;
        push_entry.ev0 = store_ev;
        count_next     = cnt_inc;
        mode_next      = too_long ? MODE_WAIT : MODE_RECV;
      end
      default: begin
        mode_next = MODE_WAIT;
      end
    endcase
    if (!take) begin
      mode_next  = mode;
      count_next = count;
      push       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_WAIT;
      count      <= 9'd0;
      start_char <= 8'd2;
      end_char   <= 8'd3;
      quote_char <= 8'd16;
      max_length <= 8'd255;
    end else begin
      mode  <= mode_next;
      count <= count_next;
      if (cfg_valid) begin
        case (reg_index_t'(cfg_index))
          REG_START_CHAR: start_char <= cfg_data;
          REG_END_CHAR:   end_char   <= cfg_data;
          REG_QUOTE_CHAR: quote_char <= cfg_data;
          REG_MAX_LENGTH: max_length <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sv/efr_queue.sv
module efr_queue #(
  parameter int DEPTH = efr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  efr_pkg::entry_t    push_entry,
  input  logic               pop,
  output efr_pkg::entry_t    head,
  output efr_pkg::q_status_t q_stat
);
  import efr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [LW-1:0]   level;
  logic            do_push;
  logic            do_pop;

  assign q_stat.nonempty = level != '0;
  assign q_stat.full     = level == LW'(DEPTH);
  assign head            = mem[rd_ptr];
  assign do_push         = push && !q_stat.full;
  assign do_pop          = pop && q_stat.nonempty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      level <= level + 1'b1;
      else if (do_pop && !do_push) level <= level - 1'b1;
    end
  end

endmodule

>>> sv/efr_back.sv
module efr_back (
  input  logic               clk,
  input  logic               rst,
  input  efr_pkg::entry_t    head,
  input  efr_pkg::q_status_t q_stat,
  output logic               pop,
  output logic               ev_valid,
  input  logic               ev_stall,
  output efr_pkg::ev_item_t  ev_beat
);
  import efr_pkg::*;

  logic second;   // head's first event already sent
  logic load;

  assign load = !ev_valid || !ev_stall;
  assign pop  = load && q_stat.nonempty && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
      second   <= 1'b0;
      ev_beat  <= '0;
    end else if (load) begin
      ev_valid <= q_stat.nonempty;
      if (q_stat.nonempty) begin
        if (second) begin
          ev_beat <= '{event_kind: head.ev1.kind, payload_byte: head.ev1.data, last: 1'b1};
          second  <= 1'b0;
        end else begin
          ev_beat <= '{event_kind: head.ev0.kind, payload_byte: head.ev0.data,
                       last: !head.two};
          second  <= head.two;
        end
      end
    end
  end

endmodule

>>> sv/escaped_frame_receiver.sv
// Start/end/quote byte deframer. Each received byte is taken whenever the
// internal event queue has room and yields zero, one or two packet-store
// events (open, store, close); the output register delivers one event per
// cycle while ev_stall is low, so throughput is one byte per cycle as long
// as bytes average at most one event and the output is not stalled. A
// byte's events pass through the queue and then the output register. A frame
// dropped by a new start byte or by exceeding max_length gets no close event.
// The configuration port is always ready; write it only while the block is idle.
module escaped_frame_receiver #(
  parameter int QUEUE_DEPTH = efr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_valid,
  output logic              rx_stall,
  input  efr_pkg::rx_item_t rx_beat,
  output logic              ev_valid,
  input  logic              ev_stall,
  output efr_pkg::ev_item_t ev_beat,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import efr_pkg::*;

  q_status_t q_stat;
  logic      push;
  logic      pop;
  entry_t    push_entry;
  entry_t    head;

  assign cfg_ready = 1'b1;

  efr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_beat    (rx_beat),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  efr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  efr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .ev_valid (ev_valid),
    .ev_stall (ev_stall),
    .ev_beat  (ev_beat)
  );

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_beat.event_kind != EV_STORE |-> ev_beat.payload_byte == 8'd0)
    else $error("non-store event carries a byte");

  a_close_last: assert property (@(posedge clk) disable iff (rst)
    ev_valid && ev_beat.event_kind == EV_CLOSE |-> ev_beat.last)
    else $error("close event not marked last");

  a_open_pair: assert property (@(posedge clk) disable iff (rst)
    ev_valid && !ev_stall && ev_beat.event_kind == EV_OPEN && !ev_beat.last |=>
      ev_valid && (ev_beat.event_kind == EV_STORE || ev_beat.event_kind == EV_CLOSE))
    else $error("second event of an open pair missing");

endmodule

>>> tb/sv/escaped_frame_receiver_tb.sv
module escaped_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efr_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 30;

  typedef enum logic [1:0] {HUNT, OPEN_NEXT, IN_FRAME, LITERAL} rx_mode_t;

  // One scripted step: a register write (cfg set, b holds the data) or a received byte.
  // typed rows carry their events; the others take them from the deframer model.
  typedef struct packed {
    logic       cfg;
    reg_index_t idx;
    logic [7:0] b;
    logic       full;
    logic       typed;
    logic [1:0] n;
    ev_item_t   e0;
    ev_item_t   e1;
  } stim_row_t;

  localparam ev_item_t NO_EV     = '0;
  localparam ev_item_t OPEN_MID  = '{EV_OPEN, 8'h00, 1'b0};
  localparam ev_item_t OPEN_END  = '{EV_OPEN, 8'h00, 1'b1};
  localparam ev_item_t CLOSE_END = '{EV_CLOSE, 8'h00, 1'b1};
  localparam int N_ROWS = 34;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_stall;
  rx_item_t  rx_beat = '0;
  logic      ev_valid;
  logic      ev_stall = 1'b0;
  ev_item_t  ev_beat;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // model state and register copies
  rx_mode_t   rx_mode = HUNT;
  logic [8:0] stored_cnt = '0;
  logic [7:0] start_q = 8'h02;
  logic [7:0] end_q = 8'h03;
  logic [7:0] quote_q = 8'h10;
  logic [7:0] max_q = 8'hFF;
  ev_item_t   step_ev [2];
  ev_item_t   expected_events [$];

  int  cycle_count = 0;
  int  mismatches = 0;
  int  events_seen = 0;
  int  bytes_in = 0;
  int  settings_used = 0;
  int  burst_left = 0;
  bit  calm = 1'b0;
  int  stall_style = 0;
  int  stall_run = 0;
  bit  stall_hold = 1'b0;

  stim_row_t script_rows [N_ROWS] = '{
    '{1'b0, REG_START_CHAR, 8'h00, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'hFF, 1'b1, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b1, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h41, 1'b0, 1'b1, 2'd2, OPEN_MID, '{EV_STORE, 8'h41, 1'b1}},
    '{1'b0, REG_START_CHAR, 8'h10, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b1, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h10, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h10, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'hFF, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h00, 1'b1, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h03, 1'b0, 1'b1, 2'd2, OPEN_MID, CLOSE_END},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h55, 1'b1, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h55, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b0, 1'b1, 2'd1, OPEN_END, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h10, 1'b0, 1'b1, 2'd1, OPEN_END, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h03, 1'b0, 1'b1, 2'd1, '{EV_STORE, 8'h03, 1'b1}, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h03, 1'b0, 1'b1, 2'd1, CLOSE_END, NO_EV},
    '{1'b1, REG_MAX_LENGTH, 8'h00, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h7E, 1'b0, 1'b1, 2'd2, OPEN_MID, '{EV_STORE, 8'h7E, 1'b1}},
    '{1'b0, REG_START_CHAR, 8'h03, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b1, REG_END_CHAR,   8'h02, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b1, REG_QUOTE_CHAR, 8'h02, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b1, REG_MAX_LENGTH, 8'hFF, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h02, 1'b0, 1'b1, 2'd1, OPEN_END, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h41, 1'b0, 1'b1, 2'd2, OPEN_MID, '{EV_STORE, 8'h41, 1'b1}},
    '{1'b1, REG_END_CHAR,   8'h10, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b1, REG_QUOTE_CHAR, 8'h10, 1'b0, 1'b0, 2'd0, NO_EV, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h10, 1'b0, 1'b1, 2'd1, CLOSE_END, NO_EV},
    '{1'b0, REG_START_CHAR, 8'h80, 1'b0, 1'b1, 2'd0, NO_EV, NO_EV}
  };

  escaped_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_beat   (rx_beat),
    .ev_valid  (ev_valid),
    .ev_stall  (ev_stall),
    .ev_beat   (ev_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Deframer model: advances the mode for one byte and fills step_ev.
  function automatic int deframe_step(rx_item_t it);
    int   n;
    logic parse;
    logic keep;
    n = 0;
    parse = 1'b0;
    keep = 1'b0;
    case (rx_mode)
      HUNT: if (it.rx_byte == start_q) rx_mode = OPEN_NEXT;
      OPEN_NEXT: begin
        stored_cnt = '0;
        if (it.store_full) begin
          rx_mode = HUNT;
        end else begin
          step_ev[n] = OPEN_MID;
          n++;
          rx_mode = IN_FRAME;
          parse = 1'b1;
        end
      end
      IN_FRAME: parse = 1'b1;
      default: keep = 1'b1;
    endcase
    // start outranks end, end outranks quote
    if (parse) begin
      if (it.rx_byte == start_q) begin
        rx_mode = OPEN_NEXT;
      end else if (it.rx_byte == end_q) begin
        step_ev[n] = '{EV_CLOSE, 8'h00, 1'b0};
        n++;
        rx_mode = HUNT;
      end else if (it.rx_byte == quote_q) begin
        rx_mode = LITERAL;
      end else begin
        keep = 1'b1;
      end
    end
    if (keep) begin
      step_ev[n] = '{EV_STORE, it.rx_byte, 1'b0};
      n++;
      if (stored_cnt != 9'd511) stored_cnt++;
      // overlong frame is dropped with no close
      rx_mode = (stored_cnt > {1'b0, max_q}) ? HUNT : IN_FRAME;
    end
    if (n > 0) step_ev[n-1].last = 1'b1;
    return n;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("ERROR @%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(rx_item_t it, bit typed, logic [1:0] tn, ev_item_t t0, ev_item_t t1);
    int gap;
    int n;
    if (burst_left == 0) begin
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    rx_valid <= 1'b1;
    rx_beat <= it;
    do @(posedge clk); while (rx_stall);
    burst_left--;
    bytes_in++;
    n = deframe_step(it);
    if (typed) begin
      if (tn > 0) expected_events.push_back(t0);
      if (tn > 1) expected_events.push_back(t1);
    end else begin
      for (int i = 0; i < n; i++) expected_events.push_back(step_ev[i]);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    rx_item_t it;
    it.rx_byte = b;
    it.store_full = ($urandom_range(0, 7) == 0);
    send_item(it, 1'b0, 2'd0, NO_EV, NO_EV);
  endtask

  // Registers only change with the pipe empty.
  task automatic write_reg(reg_index_t idx, logic [7:0] val);
    rx_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_CHAR: start_q = val;
      REG_END_CHAR:   end_q = val;
      REG_QUOTE_CHAR: quote_q = val;
      default:        max_q = val;
    endcase
  endtask

  task automatic set_regs(logic [7:0] s, logic [7:0] e, logic [7:0] q, logic [7:0] m);
    write_reg(REG_START_CHAR, s);
    write_reg(REG_END_CHAR, e);
    write_reg(REG_QUOTE_CHAR, q);
    write_reg(REG_MAX_LENGTH, m);
    settings_used++;
  endtask

  // tidy frames escape control bytes and end properly; the rest are left broken
  task automatic send_frame(int len, bit tidy);
    logic [7:0] b;
    send_byte(start_q);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 11))
        0: b = start_q;
        1: b = end_q;
        2: b = quote_q;
        default: ;
      endcase
      if (tidy && (b == start_q || b == end_q || b == quote_q)) send_byte(quote_q);
      send_byte(b);
    end
    if (tidy) send_byte(end_q);
    else if ($urandom_range(0, 1) == 1) send_byte(start_q);
  endtask

  always @(posedge clk) begin : ev_sink
    ev_item_t want;
    if (!rst && ev_valid && !ev_stall) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        flag_mismatch("event with none pending", ev_beat.event_kind, 0);
      end else begin
        want = expected_events.pop_front();
        if (ev_beat.event_kind !== want.event_kind)
          flag_mismatch("event_kind", ev_beat.event_kind, want.event_kind);
        if (ev_beat.payload_byte !== want.payload_byte)
          flag_mismatch("payload_byte", ev_beat.payload_byte, want.payload_byte);
        if (ev_beat.last !== want.last)
          flag_mismatch("last", ev_beat.last, want.last);
      end
    end
    if (cycle_count % 97 == 0) stall_style = $urandom_range(0, 2);
    case (stall_style)
      0: ev_stall <= 1'b0;
      1: ev_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run = $urandom_range(1, 6);
        end
        stall_run--;
        ev_stall <= stall_hold;
      end
    endcase
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d events outstanding", cycle_count,
             expected_events.size());
    $display("simulation failed");
    $finish;
  end

  initial begin
    int phase_end;
    int len;
    rx_item_t it;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      if (script_rows[i].cfg) begin
        write_reg(script_rows[i].idx, script_rows[i].b);
      end else begin
        it.rx_byte = script_rows[i].b;
        it.store_full = script_rows[i].full;
        send_item(it, script_rows[i].typed, script_rows[i].n, script_rows[i].e0,
                  script_rows[i].e1);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_regs(8'h02, 8'h03, 8'h10, 8'hFF);
        1: set_regs(8'h00, 8'h00, 8'h00, 8'h00);
        2: set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 6)));
        4: set_regs(8'h7E, 8'h7D, 8'h7C, 8'h01);
        default: set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      calm = ($urandom_range(0, 3) == 0);
      // one frame long enough to run the count past 255
      if (ph == 0) send_frame(257, 1'b1);
      phase_end = bytes_in + PHASE_BYTES;
      while (bytes_in < phase_end) begin
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) len = $urandom_range(0, 40);
        else len = $urandom_range(0, (max_q < 8) ? max_q + 2 : 10);
        send_frame(len, $urandom_range(0, 4) != 0);
      end
    end

    rx_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 2) @(posedge clk);
    $display("%0d bytes sent under %0d register settings plus scripted rows", bytes_in,
             settings_used);
    $display("%0d events checked, %0d mismatches", events_seen, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
sv/efr_pkg.sv
sv/efr_front.sv
sv/efr_queue.sv
sv/efr_back.sv
sv/escaped_frame_receiver.sv
tb/sv/escaped_frame_receiver_tb.sv
